// File: src/qat_pkg.sv
// Package for the quoted argument tokenizer.
// Holds the scan mode type, the result record and the character codes.
// No dependencies; the other source files refer to it by scoped names.
package qat_pkg;

    localparam int unsigned CharWidth = 8;

    typedef logic [CharWidth-1:0] t_char;

    localparam t_char ChNul       = 8'h00;
    localparam t_char ChTab       = 8'h09;
    localparam t_char ChSpace     = 8'h20;
    localparam t_char ChDquote    = 8'h22;
    localparam t_char ChSquote    = 8'h27;
    localparam t_char ChBackslash = 8'h5C;

    // Scan modes. The unused code 7 behaves as MODE_BETWEEN.
    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_BARE    = 3'd1,
        MODE_BARE_ESC = 3'd2,
        MODE_SQ      = 3'd3,
        MODE_SQ_ESC  = 3'd4,
        MODE_DQ      = 3'd5,
        MODE_DQ_ESC  = 3'd6
    } t_scan_mode;

    // One result item.
    typedef struct packed {
        logic  new_arg;
        logic  has_char;
        t_char out_char;
        logic  done_res;
        logic  aborted;
    } t_result;

endpackage

// File: src/qat_if.sv
// Stream interfaces of the quoted argument tokenizer: input characters and results.
// Each carries valid, ready and its payload. Depends on qat_pkg.
interface qat_in_if;
    logic             valid;
    logic             ready;
    qat_pkg::t_char   ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface qat_out_if;
    logic             valid;
    logic             ready;
    logic             new_arg;
    logic             has_char;
    qat_pkg::t_char   out_char;
    logic             done_res;
    logic             aborted;

    modport source (output valid, output new_arg, output has_char, output out_char,
                    output done_res, output aborted, input ready);
    modport sink   (input valid, input new_arg, input has_char, input out_char,
                    input done_res, input aborted, output ready);
endinterface

// File: src/qat_step.sv
// Next scan mode and result for one character of the quoted argument tokenizer.
// Purely combinational. Depends on qat_pkg.
module qat_step (
    input  qat_pkg::t_scan_mode i_mode,
    input  qat_pkg::t_char      i_ch,
    output qat_pkg::t_scan_mode o_mode,
    output qat_pkg::t_result    o_res
);

    logic is_nul;
    logic is_ws;
    logic is_quote;
    logic closes;
    qat_pkg::t_scan_mode open_mode;
    qat_pkg::t_result    open_res;

    assign is_nul   = (i_ch == qat_pkg::ChNul);
    assign is_ws    = (i_ch == qat_pkg::ChSpace) || (i_ch == qat_pkg::ChTab);
    assign is_quote = (i_ch == qat_pkg::ChSquote) || (i_ch == qat_pkg::ChDquote);
    assign closes   = ((i_mode == qat_pkg::MODE_SQ) && (i_ch == qat_pkg::ChSquote)) ||
                      ((i_mode == qat_pkg::MODE_DQ) && (i_ch == qat_pkg::ChDquote));

    // Opening a new argument at a non-blank, non-zero character.
    always_comb begin
        open_res          = '0;
        open_res.new_arg  = 1'b1;
        if (i_ch == qat_pkg::ChSquote) begin
            open_mode = qat_pkg::MODE_SQ;
        end else if (i_ch == qat_pkg::ChDquote) begin
            open_mode = qat_pkg::MODE_DQ;
        end else if (i_ch == qat_pkg::ChBackslash) begin
            open_mode = qat_pkg::MODE_BARE_ESC;
        end else begin
            open_mode         = qat_pkg::MODE_BARE;
            open_res.has_char = 1'b1;
            open_res.out_char = i_ch;
        end
    end

    always_comb begin
        o_mode = i_mode;
        o_res  = '0;
        case (i_mode)
            qat_pkg::MODE_BARE: begin
                if (is_nul) begin
                    o_mode         = qat_pkg::MODE_BETWEEN;
                    o_res.done_res = 1'b1;
                end else if (is_ws) begin
                    o_mode = qat_pkg::MODE_BETWEEN;
                end else if (is_quote) begin
                    o_mode = open_mode;
                    o_res  = open_res;
                end else if (i_ch == qat_pkg::ChBackslash) begin
                    o_mode = qat_pkg::MODE_BARE_ESC;
                end else begin
                    o_res.has_char = 1'b1;
                    o_res.out_char = i_ch;
                end
            end
            qat_pkg::MODE_BARE_ESC: begin
                o_res.has_char = 1'b1;
                if (is_nul) begin
                    // A trailing backslash is kept as a literal character.
                    o_mode         = qat_pkg::MODE_BETWEEN;
                    o_res.out_char = qat_pkg::ChBackslash;
                    o_res.done_res = 1'b1;
                end else begin
                    o_mode         = qat_pkg::MODE_BARE;
                    o_res.out_char = i_ch;
                end
            end
            qat_pkg::MODE_SQ, qat_pkg::MODE_DQ: begin
                if (is_nul) begin
                    o_mode         = qat_pkg::MODE_BETWEEN;
                    o_res.done_res = 1'b1;
                    o_res.aborted  = 1'b1;
                end else if (closes) begin
                    o_mode = qat_pkg::MODE_BETWEEN;
                end else if (i_ch == qat_pkg::ChBackslash) begin
                    o_mode = (i_mode == qat_pkg::MODE_SQ) ? qat_pkg::MODE_SQ_ESC
                                                          : qat_pkg::MODE_DQ_ESC;
                end else begin
                    o_res.has_char = 1'b1;
                    o_res.out_char = i_ch;
                end
            end
            qat_pkg::MODE_SQ_ESC, qat_pkg::MODE_DQ_ESC: begin
                if (is_nul) begin
                    o_mode         = qat_pkg::MODE_BETWEEN;
                    o_res.done_res = 1'b1;
                    o_res.aborted  = 1'b1;
                end else begin
                    o_mode = (i_mode == qat_pkg::MODE_SQ_ESC) ? qat_pkg::MODE_SQ
                                                              : qat_pkg::MODE_DQ;
                    o_res.has_char = 1'b1;
                    o_res.out_char = i_ch;
                end
            end
            default: begin
                // Between arguments, and the unused mode code.
                if (is_nul) begin
                    o_mode         = qat_pkg::MODE_BETWEEN;
                    o_res.done_res = 1'b1;
                end else if (is_ws) begin
                    o_mode = qat_pkg::MODE_BETWEEN;
                end else begin
                    o_mode = open_mode;
                    o_res  = open_res;
                end
            end
        endcase
    end

endmodule

// File: src/quoted_argument_tokenizer.sv
// Top level of the quoted argument tokenizer.
// Depends on qat_pkg, the interfaces in qat_if.sv and the qat_step module.

// Splits a character stream into shell-style arguments, one character per
// transfer, and gives exactly one result transfer for every input transfer.
// Space and tab separate arguments; single and double quotes group text and
// are removed; a backslash makes the next character literal. A zero byte ends
// the string: its result has done_res set, and aborted set as well when a quote
// was left open, in which case the last argument should be dropped. After the
// zero byte the tokenizer is back between arguments, ready for a new string.
// Throughput is one character per clock cycle while results are taken. An
// input transfer captures the character in the input register; the mode logic
// then writes its result into the result register while the scan mode register
// advances, and the result is offered from there. The input stays ready while
// a result waits, as long as the input register is free to move on, so stalls
// cost nothing beyond the two-entry buffering.
module quoted_argument_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qat_in_if.sink     i_in,
    qat_out_if.source  o_out
);

    // Input register.
    logic                r_in_valid;
    qat_pkg::t_char      r_in_ch;

    // Scan mode and result register.
    qat_pkg::t_scan_mode r_mode;
    qat_pkg::t_scan_mode n_mode;
    logic                r_out_valid;
    qat_pkg::t_result    r_res;
    qat_pkg::t_result    n_res;

    logic                advance;
    logic                in_xfer;
    logic                out_xfer;

    qat_step u_step (
        .i_mode (r_mode),
        .i_ch   (r_in_ch),
        .o_mode (n_mode),
        .o_res  (n_res)
    );

    // The held character moves into the result register when that register
    // is empty or its result is taken in the same cycle.
    assign out_xfer   = r_out_valid && o_out.ready;
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= qat_pkg::MODE_BETWEEN;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_ch <= i_in.ch;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.new_arg  = r_res.new_arg;
    assign o_out.has_char = r_res.has_char;
    assign o_out.out_char = r_res.out_char;
    assign o_out.done_res = r_res.done_res;
    assign o_out.aborted  = r_res.aborted;

endmodule

// File: test/qat_result_checker.sv
// Result checker for the quoted argument tokenizer testbench.
// Watches both stream interfaces, predicts each result from the characters and compares.
// Depends on qat_pkg and the interfaces in qat_if.sv.
module qat_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qat_in_if           i_chars,
    qat_out_if          i_results,
    output int unsigned o_fail_count,
    output int unsigned o_pending_count,
    output int unsigned o_checked_count
);
    import qat_pkg::*;

    t_scan_mode  scan_state;
    t_result     expected_results[$];
    int unsigned fail_count;
    int unsigned checked_count;

    // First character of an argument; quotes and a backslash are consumed.
    function automatic t_result open_argument(input t_char ch);
        t_result res;
        res = '0;
        res.new_arg = 1'b1;
        if (ch == ChSquote) begin
            scan_state = MODE_SQ;
        end else if (ch == ChDquote) begin
            scan_state = MODE_DQ;
        end else if (ch == ChBackslash) begin
            scan_state = MODE_BARE_ESC;
        end else begin
            scan_state   = MODE_BARE;
            res.has_char = 1'b1;
            res.out_char = ch;
        end
        return res;
    endfunction

    // Advances the scan mode by one character and returns the result it gives.
    function automatic t_result tokenize_char(input t_char ch);
        t_result res;
        res = '0;
        case (scan_state)
            MODE_BARE: begin
                if (ch == ChNul) begin
                    scan_state   = MODE_BETWEEN;
                    res.done_res = 1'b1;
                end else if (ch == ChSpace || ch == ChTab) begin
                    scan_state = MODE_BETWEEN;
                end else if (ch == ChSquote || ch == ChDquote) begin
                    res = open_argument(ch);
                end else if (ch == ChBackslash) begin
                    scan_state = MODE_BARE_ESC;
                end else begin
                    res.has_char = 1'b1;
                    res.out_char = ch;
                end
            end
            MODE_BARE_ESC: begin
                // A bare backslash at the end of the string is kept.
                res.has_char = 1'b1;
                if (ch == ChNul) begin
                    scan_state   = MODE_BETWEEN;
                    res.out_char = ChBackslash;
                    res.done_res = 1'b1;
                end else begin
                    scan_state   = MODE_BARE;
                    res.out_char = ch;
                end
            end
            MODE_SQ, MODE_DQ: begin
                if (ch == ChNul) begin
                    scan_state   = MODE_BETWEEN;
                    res.done_res = 1'b1;
                    res.aborted  = 1'b1;
                end else if (ch == ((scan_state == MODE_SQ) ? ChSquote : ChDquote)) begin
                    scan_state = MODE_BETWEEN;
                end else if (ch == ChBackslash) begin
                    scan_state = (scan_state == MODE_SQ) ? MODE_SQ_ESC : MODE_DQ_ESC;
                end else begin
                    res.has_char = 1'b1;
                    res.out_char = ch;
                end
            end
            MODE_SQ_ESC, MODE_DQ_ESC: begin
                if (ch == ChNul) begin
                    scan_state   = MODE_BETWEEN;
                    res.done_res = 1'b1;
                    res.aborted  = 1'b1;
                end else begin
                    scan_state   = (scan_state == MODE_SQ_ESC) ? MODE_SQ : MODE_DQ;
                    res.has_char = 1'b1;
                    res.out_char = ch;
                end
            end
            default: begin
                if (ch == ChNul) begin
                    scan_state   = MODE_BETWEEN;
                    res.done_res = 1'b1;
                end else if (ch == ChSpace || ch == ChTab) begin
                    scan_state = MODE_BETWEEN;
                end else begin
                    res = open_argument(ch);
                end
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            scan_state = MODE_BETWEEN;
            expected_results.delete();
        end else begin
            if (i_chars.valid && i_chars.ready) begin
                expected_results.push_back(tokenize_char(i_chars.ch));
            end
            if (i_results.valid && i_results.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no character waiting for it");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("new_arg", want.new_arg, i_results.new_arg);
                    check_field("has_char", want.has_char, i_results.has_char);
                    check_field("out_char", want.out_char, i_results.out_char);
                    check_field("done_res", want.done_res, i_results.done_res);
                    check_field("aborted", want.aborted, i_results.aborted);
                    checked_count++;
                end
            end
        end
        o_fail_count    <= fail_count;
        o_pending_count <= expected_results.size();
        o_checked_count <= checked_count;
    end

endmodule

// File: test/tb_top.sv
// Top of the quoted argument tokenizer testbench: clock, reset, stimulus and verdict.
// Depends on qat_pkg, qat_if.sv, the tokenizer RTL and qat_result_checker.
module tb_top;
    import qat_pkg::*;

    // The random part stops once this many characters have been offered after
    // the directed ones.
    localparam int unsigned RandomChars   = 550;
    // Percentage of cycles in which either side idles outside the calm stretch.
    localparam int unsigned IdlePercent   = 23;
    // The receiver holds off once, long enough for the two-entry buffering of the
    // input and result registers to fill so that the input stalls.
    localparam int unsigned HoldOffStart  = 300;
    localparam int unsigned HoldOffCycles = 64;
    // Cycles without any transfer before the run is declared hung.
    localparam int unsigned QuietLimit    = 2000;
    // Cycles allowed after the last result.
    localparam int unsigned DrainCycles   = 10;

    // Directed characters, in the order they are sent. Each line notes the
    // behavior that the character is meant to reach.
    localparam int unsigned DirectedCount = 25;
    localparam t_char DirectedChars [0:DirectedCount-1] = '{
        ChSpace,      // whitespace between arguments
        ChTab,        // tab is whitespace too
        8'h61,        // plain character opens a bare argument
        8'hFF,        // top character value inside a bare argument
        ChDquote,     // quote right after a bare argument opens a new one
        ChBackslash,  // backslash inside double quotes
        ChDquote,     // escaped quote is literal
        ChDquote,     // closing quote
        8'h78,        // character right after a closing quote opens a new argument
        ChBackslash,  // backslash in a bare argument
        ChBackslash,  // doubled backslash gives one literal backslash
        ChSpace,      // ... and does not escape the space that follows
        ChSquote,     // opens a single-quoted argument
        ChSquote,     // empty quotes: an argument with no characters
        ChBackslash,  // backslash opening an argument
        ChNul,        // trailing bare backslash is kept with the end of string
        ChDquote,     // open double quote
        ChNul,        // end of string inside quotes: aborted
        ChSquote,     // open single quote
        8'h71,        // plain character inside single quotes
        ChBackslash,  // backslash inside single quotes
        ChNul,        // end of string right after a backslash in quotes: aborted
        8'h01,        // lowest nonzero character opens a bare argument
        ChNul,        // end of string from a bare argument
        ChNul         // empty string, end of string between arguments
    };

    localparam t_char NoiseSpecials [0:5] = '{
        ChNul, ChTab, ChSpace, ChDquote, ChSquote, ChBackslash
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Set while the middle of the random part runs; neither side idles then.
    bit calm_phase = 1'b0;

    int unsigned chars_sent;
    int unsigned strings_sent;
    int unsigned open_quote_strings;
    int unsigned noise_strings;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned checked_count;

    qat_in_if  char_bus ();
    qat_out_if result_bus ();

    quoted_argument_tokenizer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (char_bus),
        .o_out   (result_bus)
    );

    qat_result_checker result_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_chars         (char_bus),
        .i_results       (result_bus),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count),
        .o_checked_count (checked_count)
    );

    always #2 clk = ~clk;

    // Offers one character and returns at the edge where it is transferred.
    // Valid is left high afterwards so that back-to-back characters never see
    // valid lowered and raised again in the same time step; idle cycles put
    // random junk on ch while valid is low.
    task automatic send_char(input t_char ch);
        calm_phase = (chars_sent >= DirectedCount + 150) &&
                     (chars_sent < DirectedCount + 270);
        while (!calm_phase && $urandom_range(99) < IdlePercent) begin
            char_bus.valid <= 1'b0;
            char_bus.ch    <= t_char'($urandom_range(255));
            @(posedge clk);
        end
        char_bus.valid <= 1'b1;
        char_bus.ch    <= ch;
        do begin
            @(posedge clk);
        end while (!char_bus.ready);
        chars_sent++;
    endtask

    // A random nonzero character that cannot end or escape the current
    // argument. Bare text also avoids whitespace and quotes.
    function automatic t_char text_char(input bit quoted, input t_char closing);
        t_char ch;
        do begin
            ch = t_char'($urandom_range(1, 255));
        end while (ch == ChBackslash || ch == closing ||
                   (!quoted && (ch == ChSpace || ch == ChTab ||
                                ch == ChSquote || ch == ChDquote)));
        return ch;
    endfunction

    // Argument text, where about one character in five is escaped; the
    // escaped character may be anything but the zero byte.
    task automatic send_text(input int unsigned len, input bit quoted, input t_char closing);
        repeat (len) begin
            if ($urandom_range(4) == 0) begin
                send_char(ChBackslash);
                send_char(t_char'($urandom_range(1, 255)));
            end else begin
                send_char(text_char(quoted, closing));
            end
        end
    endtask

    // One string of bare words, quoted words and whitespace in random order,
    // so bare and quoted words often touch. With leave_open set a quote is
    // opened near the end and never closed before the zero byte.
    task automatic send_string(input bit leave_open);
        t_char quote;
        repeat ($urandom_range(1, 4)) begin
            quote = $urandom_range(1) ? ChSquote : ChDquote;
            case ($urandom_range(2))
                0: send_text($urandom_range(1, 5), 1'b0, ChNul);
                1: begin
                    send_char(quote);
                    send_text($urandom_range(0, 4), 1'b1, quote);
                    send_char(quote);
                end
                default: begin
                    repeat ($urandom_range(1, 3)) begin
                        send_char($urandom_range(1) ? ChSpace : ChTab);
                    end
                end
            endcase
        end
        if (leave_open) begin
            quote = $urandom_range(1) ? ChSquote : ChDquote;
            send_char(quote);
            send_text($urandom_range(0, 3), 1'b1, quote);
            if ($urandom_range(1)) begin
                send_char(ChBackslash);
            end
        end
        send_char(ChNul);
    endtask

    // Noise: characters of any value, heavy on the special ones. The zero byte
    // is often missing, so the next string starts in whatever mode this one
    // left behind.
    task automatic send_noise();
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(1)) begin
                send_char(NoiseSpecials[$urandom_range(5)]);
            end else begin
                send_char(t_char'($urandom_range(255)));
            end
        end
        if ($urandom_range(9) < 7) begin
            send_char(ChNul);
        end
    endtask

    // Reset is synchronous and asserted once, at the start of the run.
    initial begin : reset_gen
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Receiver: random stalls, none during the calm stretch, and one long
    // hold-off counted here so the input side backs up behind it.
    initial begin : receiver
        int unsigned cycle_count;
        cycle_count = 0;
        result_bus.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (cycle_count == HoldOffStart) begin
                result_bus.ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge clk);
            end else if (calm_phase) begin
                result_bus.ready <= 1'b1;
            end else begin
                result_bus.ready <= ($urandom_range(99) >= IdlePercent);
            end
            cycle_count++;
            @(posedge clk);
        end
    end

    // Any cycle with a transfer on either side restarts the count; a long
    // silence means the block has hung or lost results.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QuietLimit) begin
            @(posedge clk);
            if ((char_bus.valid && char_bus.ready) || (result_bus.valid && result_bus.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $error("no transfer for %0d cycles, %0d results still expected",
               QuietLimit, pending_count);
        $display("** quoted_argument_tokenizer: FAILED **");
        $finish;
    end

    // Stimulus: directed characters first, then random strings until enough
    // characters have gone in. Most strings are well formed; the rest leave a
    // quote open or are noise.
    initial begin : stimulus
        int unsigned pick;
        char_bus.valid <= 1'b0;
        char_bus.ch    <= ChNul;
        while (!rst_n) @(posedge clk);

        foreach (DirectedChars[i]) begin
            send_char(DirectedChars[i]);
        end

        while (chars_sent < DirectedCount + RandomChars) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_string(1'b0);
            end else if (pick < 88) begin
                send_string(1'b1);
                open_quote_strings++;
            end else begin
                send_noise();
                noise_strings++;
            end
            strings_sent++;
        end
        char_bus.valid <= 1'b0;

        // The pending count is registered in the checker, so it shows the last
        // character only in the cycle after. Wait for every expected result, then
        // for DrainCycles more so that a stray extra result would still be caught.
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Sent %0d characters: %0d directed, then %0d random strings",
                 chars_sent, DirectedCount, strings_sent);
        $display("(%0d with an open quote, %0d noise); checked %0d results %s",
                 open_quote_strings, noise_strings, checked_count,
                 "under random stalls on both sides and one long receiver hold-off.");
        if (fail_count == 0) begin
            $display("** quoted_argument_tokenizer: PASSED **");
        end else begin
            $display("** quoted_argument_tokenizer: FAILED **");
        end
        $finish;
    end

endmodule
